@@ rtl/core/crf_pkg.sv @@
// Shared types and constants for the consumption rate forecaster.
// No dependencies; imported by every module of the block.
package crf_pkg;

    localparam int WINDOW_SLOTS = 7;
    localparam int SLOT_W       = $clog2(WINDOW_SLOTS);
    localparam int CNT_W        = $clog2(WINDOW_SLOTS + 1);

    localparam int TIME_W = 32;
    localparam int MASS_W = 24;
    localparam int RATE_W = 24;
    localparam int DAYS_W = 24;
    localparam int SNAP_W = MASS_W + TIME_W;

    localparam logic [TIME_W-1:0] VALID_TIME  = 32'd1700000000;
    localparam logic [16:0]       DAY_SECONDS = 17'd86400;
    localparam logic [TIME_W-1:0] MIN_SPAN    = 32'd3600;
    localparam logic [MASS_W-1:0] MIN_DELTA   = 24'd2;

    // shared divider: 41-bit dividend (24 x 17 product), 32-bit divisor
    localparam int PROD_W    = MASS_W + 17;
    localparam int DIV_N_W   = PROD_W;
    localparam int DIV_D_W   = 32;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 80;

    typedef enum logic [1:0] {
        OP_RATE = 2'd0,
        OP_DAYS = 2'd1,
        OP_SECS = 2'd2
    } div_op_t;

    typedef struct packed {
        logic    capture;
        logic    update;
        logic    rd_newest;
        logic    rd_oldest;
        logic    latch_oldest;
        logic    prep;
        logic    div_start;
        div_op_t div_op;
        logic    out_load;
    } crf_cmd_t;

    typedef struct packed {
        logic window_ok;
        logic rate_ok;
        logic days_ok;
        logic div_done;
        logic out_free;
    } crf_status_t;

endpackage

@@ rtl/core/crf_div.sv @@
// Restoring divider, one quotient bit per cycle, 41-bit dividend by 32-bit divisor.
// Depends on crf_pkg for widths.
module crf_div
    import crf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic [DIV_N_W-1:0] quotient,
    output logic               done
);

    logic [DIV_N_W-1:0]   quo_reg, quo_next;
    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_D_W-1:0]   dsr_reg;
    logic [DIV_CNT_W-1:0] count_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_D_W:0]     trial;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[DIV_N_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb begin
        rem_next = fits ? DIV_D_W'(trial - {1'b0, dsr_reg}) : trial[DIV_D_W-1:0];
        quo_next = {quo_reg[DIV_N_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                count_reg <= DIV_CNT_W'(DIV_N_W - 1);
            end else if (busy_reg) begin
                if (count_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    count_reg <= count_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

@@ rtl/core/crf_datapath.sv @@
// Datapath: snapshot ring memory, window arithmetic, shared divider, output register.
// Depends on crf_pkg and crf_div; driven by crf_ctrl through crf_cmd_t.
module crf_datapath
    import crf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  crf_cmd_t              cmd,
    output crf_status_t           status,
    input  logic [0:0]            s_axis_tuser,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [0:0]            m_axis_tuser,
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // captured item
    logic              query_reg;
    logic [TIME_W-1:0] now_reg;
    logic [MASS_W-1:0] consumed_reg;
    logic [MASS_W-1:0] remaining_reg;
    logic              time_ok;

    // ring state
    logic [SNAP_W-1:0] snap_mem [WINDOW_SLOTS];
    logic [SNAP_W-1:0] rd_data_reg;
    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic [CNT_W-1:0]  filled_reg;
    logic [TIME_W-1:0] last_time_reg;
    logic [TIME_W-1:0] since_last;
    logic              take_snap;
    logic              taken_reg;
    logic [SLOT_W-1:0] newest_idx, oldest_idx, rd_idx;
    logic [CNT_W:0]    oldest_sum;

    // window
    logic [SNAP_W-1:0] newest_reg, oldest_reg;
    logic [MASS_W-1:0] mass_new, mass_old, dm;
    logic [TIME_W-1:0] dt;
    logic              win_ok;
    logic              window_ok_reg;
    logic [PROD_W-1:0] mass_prod_reg, rem_prod_reg;
    logic [TIME_W-1:0] dt_reg;

    // results
    logic [RATE_W-1:0] rate_reg;
    logic [DAYS_W-1:0] days_reg;
    logic [TIME_W-1:0] secs_reg;
    logic              empty_ok_reg;
    logic [TIME_W-1:0] empty_time;

    // divider
    div_op_t            op_reg;
    logic [DIV_N_W-1:0] div_dividend, div_quotient;
    logic [DIV_D_W-1:0] div_divisor;
    logic               div_done;

    logic                  out_valid_reg;
    logic                  out_taken_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    assign time_ok    = now_reg >= VALID_TIME;
    assign since_last = now_reg - last_time_reg;
    assign take_snap  = !query_reg && time_ok
                        && (last_time_reg == '0 || since_last >= TIME_W'(DAY_SECONDS));

    assign write_slot_next = (write_slot_reg == SLOT_W'(WINDOW_SLOTS - 1))
                             ? '0 : write_slot_reg + 1'b1;
    assign newest_idx = (write_slot_reg == '0)
                        ? SLOT_W'(WINDOW_SLOTS - 1) : write_slot_reg - 1'b1;

    // (write_slot + WINDOW_SLOTS - filled) mod WINDOW_SLOTS, sum below twice the depth
    always_comb begin
        oldest_sum = (CNT_W+1)'(write_slot_reg) + (CNT_W+1)'(WINDOW_SLOTS)
                     - (CNT_W+1)'(filled_reg);
        if (oldest_sum >= (CNT_W+1)'(WINDOW_SLOTS)) begin
            oldest_idx = SLOT_W'(oldest_sum - (CNT_W+1)'(WINDOW_SLOTS));
        end else begin
            oldest_idx = SLOT_W'(oldest_sum);
        end
    end

    assign rd_idx = cmd.rd_newest ? newest_idx : oldest_idx;

    always_ff @(posedge aclk) begin
        if (cmd.update && take_snap) begin
            snap_mem[write_slot_reg] <= {consumed_reg, now_reg};
        end
        rd_data_reg <= snap_mem[rd_idx];
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            query_reg     <= s_axis_tuser[0];
            now_reg       <= s_axis_tdata[31:0];
            consumed_reg  <= s_axis_tdata[55:32];
            remaining_reg <= s_axis_tdata[79:56];
        end
        if (cmd.rd_oldest) begin
            newest_reg <= rd_data_reg;
        end
        if (cmd.latch_oldest) begin
            oldest_reg <= rd_data_reg;
        end
        if (cmd.prep) begin
            mass_prod_reg <= PROD_W'(dm) * PROD_W'(DAY_SECONDS);
            rem_prod_reg  <= PROD_W'(remaining_reg) * PROD_W'(DAY_SECONDS);
            dt_reg        <= dt;
        end
        if (cmd.div_start) begin
            op_reg <= cmd.div_op;
        end
    end

    assign mass_new = newest_reg[SNAP_W-1:TIME_W];
    assign mass_old = oldest_reg[SNAP_W-1:TIME_W];
    assign dm       = mass_new - mass_old;
    assign dt       = newest_reg[TIME_W-1:0] - oldest_reg[TIME_W-1:0];
    assign win_ok   = (filled_reg >= CNT_W'(2)) && (mass_new > mass_old)
                      && (dt >= MIN_SPAN) && (dm > MIN_DELTA);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_slot_reg <= '0;
            filled_reg     <= '0;
            last_time_reg  <= '0;
            taken_reg      <= 1'b0;
            window_ok_reg  <= 1'b0;
            rate_reg       <= '0;
            days_reg       <= '0;
            secs_reg       <= '0;
            empty_ok_reg   <= 1'b0;
        end else begin
            if (cmd.capture) begin
                taken_reg <= 1'b0;
            end
            if (cmd.update && take_snap) begin
                write_slot_reg <= write_slot_next;
                last_time_reg  <= now_reg;
                taken_reg      <= 1'b1;
                if (filled_reg != CNT_W'(WINDOW_SLOTS)) begin
                    filled_reg <= filled_reg + 1'b1;
                end
            end
            if (cmd.prep) begin
                window_ok_reg <= win_ok;
                rate_reg      <= '0;
                days_reg      <= '0;
                empty_ok_reg  <= 1'b0;
            end
            if (div_done) begin
                case (op_reg)
                    OP_RATE: begin
                        rate_reg <= (div_quotient[DIV_N_W-1:RATE_W] != '0)
                                    ? '1 : div_quotient[RATE_W-1:0];
                    end
                    OP_DAYS: begin
                        days_reg <= (div_quotient[DIV_N_W-1:DAYS_W] != '0)
                                    ? '1 : div_quotient[DAYS_W-1:0];
                    end
                    OP_SECS: begin
                        secs_reg     <= (div_quotient[DIV_N_W-1:TIME_W] != '0)
                                        ? '1 : div_quotient[TIME_W-1:0];
                        empty_ok_reg <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        case (cmd.div_op)
            OP_RATE: begin
                div_dividend = mass_prod_reg;
                div_divisor  = dt_reg;
            end
            OP_DAYS: begin
                div_dividend = DIV_N_W'({remaining_reg, 8'h00});
                div_divisor  = DIV_D_W'(rate_reg);
            end
            default: begin
                div_dividend = rem_prod_reg;
                div_divisor  = DIV_D_W'(rate_reg);
            end
        endcase
    end

    crf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    assign empty_time = empty_ok_reg ? now_reg + secs_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_taken_reg <= taken_reg;
            out_data_reg  <= {empty_time, days_reg, rate_reg};
        end
    end

    assign status.window_ok = window_ok_reg;
    assign status.rate_ok   = (rate_reg > RATE_W'(MIN_DELTA)) && (remaining_reg != '0);
    assign status.days_ok   = (days_reg != '0) && time_ok;
    assign status.div_done  = div_done;
    assign status.out_free  = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tuser[0] = out_taken_reg;
    assign m_axis_tdata    = out_data_reg;

    a_filled_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        filled_reg <= CNT_W'(WINDOW_SLOTS))
        else $error("snapshot count beyond window depth");

    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        write_slot_reg < SLOT_W'(WINDOW_SLOTS))
        else $error("write slot outside ring");

    a_snap_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update && take_snap |=> filled_reg != '0 && taken_reg)
        else $error("snapshot store did not register");

    a_days_need_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        days_reg != '0 |-> rate_reg > RATE_W'(MIN_DELTA))
        else $error("days reported without a usable rate");

endmodule

@@ rtl/core/crf_ctrl.sv @@
// Controller state machine: sequences capture, ring update, window reads and divisions.
// Depends on crf_pkg; talks to crf_datapath through crf_cmd_t / crf_status_t.
module crf_ctrl
    import crf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  crf_status_t status,
    output crf_cmd_t    cmd
);

    typedef enum logic [12:0] {
        ST_IDLE      = 13'b0000000000001,
        ST_UPDATE    = 13'b0000000000010,
        ST_RD_NEW    = 13'b0000000000100,
        ST_RD_OLD    = 13'b0000000001000,
        ST_RD_LAT    = 13'b0000000010000,
        ST_PREP      = 13'b0000000100000,
        ST_RATE_GO   = 13'b0000001000000,
        ST_RATE_WAIT = 13'b0000010000000,
        ST_DAYS_GO   = 13'b0000100000000,
        ST_DAYS_WAIT = 13'b0001000000000,
        ST_SECS_GO   = 13'b0010000000000,
        ST_SECS_WAIT = 13'b0100000000000,
        ST_FINISH    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_op = OP_RATE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_RD_NEW;
            end
            ST_RD_NEW: begin
                cmd.rd_newest = 1'b1;
                state_next    = ST_RD_OLD;
            end
            ST_RD_OLD: begin
                cmd.rd_oldest = 1'b1;
                state_next    = ST_RD_LAT;
            end
            ST_RD_LAT: begin
                cmd.latch_oldest = 1'b1;
                state_next       = ST_PREP;
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_RATE_GO;
            end
            ST_RATE_GO: begin
                if (status.window_ok) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_RATE_WAIT;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_RATE_WAIT: begin
                if (status.div_done) begin
                    state_next = ST_DAYS_GO;
                end
            end
            ST_DAYS_GO: begin
                cmd.div_op = OP_DAYS;
                if (status.rate_ok) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DAYS_WAIT;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_DAYS_WAIT: begin
                if (status.div_done) begin
                    state_next = ST_SECS_GO;
                end
            end
            ST_SECS_GO: begin
                cmd.div_op = OP_SECS;
                if (status.days_ok) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_SECS_WAIT;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_SECS_WAIT: begin
                if (status.div_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold here while the previous result is still unclaimed
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_accept_goes_update: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> state_reg == ST_UPDATE)
        else $error("accepted item did not start the sequence");

    a_wait_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RATE_WAIT && !status.div_done |=> state_reg == ST_RATE_WAIT)
        else $error("left rate wait before divider finished");

    a_load_only_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("output register overwritten");

endmodule

@@ rtl/core/consumption_rate_forecaster_core.sv @@
// Consumption rate forecaster: daily snapshot ring and rate / days / empty-time forecast.
// Top level; depends on crf_pkg, crf_ctrl, crf_datapath (with crf_div).
//
// Usage:
//   Input items arrive on s_axis: tuser[0] is the command (0 tick, 1 query only),
//   tdata carries time, consumed mass and remaining mass. One result item per input
//   leaves on m_axis: tuser[0] flags a stored snapshot, tdata carries rate, days
//   remaining and forecast empty time.
//   One item is worked at a time. When the window gives no rate the result is loaded
//   without any division; otherwise up to three divisions (rate, days, empty time) run
//   in turn on the shared 41-step restoring divider, each later one only when the one
//   before gave a usable result.
//   s_axis_tready rises again on the edge that loads the result, so the next item
//   is taken only after the previous result has been loaded.
//   Results sit in an output register: a stalled receiver does not block the next
//   input item, but a second result waits in the controller until the first is taken.
//   Reset (aresetn low, synchronous) empties the snapshot ring, clears the last
//   snapshot time and drops any pending result. Snapshot storage has no clear pass;
//   unwritten slots can be read, but no window is used until two snapshots are stored.
module consumption_rate_forecaster_core
    import crf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [0:0]            s_axis_tuser,   // [0] cmd
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [31:0] current_time,
                                                  // [55:32] consumed_since_refill,
                                                  // [79:56] remaining_mass
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [0:0]            m_axis_tuser,   // [0] snapshot_taken
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // [23:0] rate_per_day,
                                                  // [47:24] days_remaining,
                                                  // [79:48] empty_time
);

    crf_cmd_t    cmd;
    crf_status_t status;

    crf_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    crf_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
